// File: design/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Shared constants, request codes and control/status types for the sample
// ring buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int DEPTH     = 1024;
    localparam int MAX_BURST = 64;

    localparam int PTR_W  = 10;                       // sample store address
    localparam int LEN_W  = 11;                       // ring length, 1..DEPTH
    localparam int CNT_W  = 10;                       // count, offset, fill
    localparam int SMP_W  = 16;                       // sample width
    localparam int ACT_W  = 3;                        // request kind
    localparam int EMIT_W = $clog2(MAX_BURST + 1);    // samples left to emit

    localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PREVIEW = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SKIP    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;       // apply the request on the input ports
        logic step;         // read one sample and load it into the output
        logic step_last;    // the sample read by this step ends the request
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic              emit;        // request streams samples
        logic              silent;      // request gives no result
        logic [EMIT_W-1:0] emit_count;  // samples to stream
    } dp_stat_t;

endpackage

// File: design/srb_dp.sv
// ----------------------------------------------------------------------------
// srb_dp
// Datapath: sample store, ring pointers, burst tracking, request checks and
// the output payload registers.
// ----------------------------------------------------------------------------
module srb_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [srb_pkg::LEN_W-1:0]    ring_length,
    input  logic [srb_pkg::ACT_W-1:0]    action,
    input  logic signed [srb_pkg::SMP_W-1:0] sample,
    input  logic                         burst_start,
    input  logic [srb_pkg::CNT_W-1:0]    count,
    input  logic [srb_pkg::CNT_W-1:0]    offset,
    input  srb_pkg::dp_cmd_t             cmd,
    output srb_pkg::dp_stat_t            stat,
    output logic signed [srb_pkg::SMP_W-1:0] data_out,
    output logic                         status,
    output logic                         last,
    output logic [srb_pkg::CNT_W-1:0]    fill_level
);

    logic [srb_pkg::SMP_W-1:0] mem [srb_pkg::DEPTH];
    logic [srb_pkg::SMP_W-1:0] rd_data_reg;

    logic [srb_pkg::LEN_W-1:0] slots_reg;
    logic [srb_pkg::PTR_W-1:0] wp_reg, wp_next;
    logic [srb_pkg::PTR_W-1:0] rp_reg, rp_next;
    logic [srb_pkg::CNT_W-1:0] left_reg, left_next;
    logic                      taken_reg, taken_next;

    logic [srb_pkg::PTR_W-1:0] emit_ptr_reg;
    logic [srb_pkg::CNT_W-1:0] emit_fill_reg;
    logic                      sel_reg;
    logic                      status_reg;
    logic                      last_reg;
    logic [srb_pkg::CNT_W-1:0] fill_reg;

    logic [srb_pkg::LEN_W-1:0] fill_wide;
    logic [srb_pkg::CNT_W-1:0] fill_now;
    logic [srb_pkg::LEN_W-1:0] space;
    logic                      cnt_ok;
    logic                      do_store;
    logic                      emit;
    logic                      silent;
    logic                      res_status;
    logic [srb_pkg::CNT_W-1:0] res_fill;
    logic [srb_pkg::PTR_W-1:0] emit_from;
    logic [srb_pkg::CNT_W-1:0] emit_level;
    logic [srb_pkg::LEN_W-1:0] slots_cfg;

    // Advance a pointer around the ring; the sum stays below twice the length
    function automatic logic [srb_pkg::PTR_W-1:0] adv(
        input logic [srb_pkg::PTR_W-1:0] p,
        input logic [srb_pkg::CNT_W-1:0] by,
        input logic [srb_pkg::LEN_W-1:0] len
    );
        logic [srb_pkg::LEN_W-1:0] sum;
        sum = {1'b0, p} + {1'b0, by};
        if (sum >= len)
        begin
            sum = sum - len;
        end
        return sum[srb_pkg::PTR_W-1:0];
    endfunction

    always_comb
    begin
        if (ring_length == '0)
        begin
            slots_cfg = srb_pkg::LEN_W'(1);
        end
        else if (ring_length > srb_pkg::LEN_W'(srb_pkg::DEPTH))
        begin
            slots_cfg = srb_pkg::LEN_W'(srb_pkg::DEPTH);
        end
        else
        begin
            slots_cfg = ring_length;
        end
    end

    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            fill_wide = {1'b0, wp_reg} - {1'b0, rp_reg};
        end
        else
        begin
            fill_wide = {1'b0, wp_reg} + slots_reg - {1'b0, rp_reg};
        end
        fill_now = fill_wide[srb_pkg::CNT_W-1:0];
        space    = slots_reg - srb_pkg::LEN_W'(1) - fill_wide;
        cnt_ok   = (count != '0) && (count <= srb_pkg::CNT_W'(srb_pkg::MAX_BURST));
    end

    // Request checks and next pointer/burst state
    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        left_next  = left_reg;
        taken_next = taken_reg;
        do_store   = 1'b0;
        emit       = 1'b0;
        silent     = 1'b0;
        res_status = 1'b1;
        res_fill   = fill_now;
        emit_from  = rp_reg;
        emit_level = fill_now;

        case (action)
            srb_pkg::ACT_WRITE:
            begin
                if (burst_start)
                begin
                    if (!cnt_ok || ({1'b0, count} > space))
                    begin
                        taken_next = 1'b0;
                        left_next  = (count != '0) ? count - srb_pkg::CNT_W'(1) : '0;
                    end
                    else
                    begin
                        do_store   = 1'b1;
                        left_next  = count - srb_pkg::CNT_W'(1);
                        taken_next = (count != srb_pkg::CNT_W'(1));
                    end
                end
                else if (left_reg == '0)
                begin
                    res_status = 1'b1;
                end
                else if (!taken_reg)
                begin
                    // drop the item of a refused burst
                    silent    = 1'b1;
                    left_next = left_reg - srb_pkg::CNT_W'(1);
                end
                else
                begin
                    do_store   = 1'b1;
                    left_next  = left_reg - srb_pkg::CNT_W'(1);
                    taken_next = (left_reg != srb_pkg::CNT_W'(1));
                end
                if (do_store)
                begin
                    wp_next    = adv(wp_reg, srb_pkg::CNT_W'(1), slots_reg);
                    res_status = 1'b0;
                    res_fill   = fill_now + srb_pkg::CNT_W'(1);
                end
            end
            srb_pkg::ACT_READ:
            begin
                if (cnt_ok && (count <= fill_now))
                begin
                    emit       = 1'b1;
                    rp_next    = adv(rp_reg, count, slots_reg);
                    emit_from  = rp_reg;
                    emit_level = fill_now - count;
                end
            end
            srb_pkg::ACT_PREVIEW:
            begin
                if (cnt_ok && (({1'b0, count} + {1'b0, offset}) <= {1'b0, fill_now}))
                begin
                    emit       = 1'b1;
                    emit_from  = adv(rp_reg, offset, slots_reg);
                    emit_level = fill_now;
                end
            end
            srb_pkg::ACT_SKIP:
            begin
                if ((count <= srb_pkg::CNT_W'(srb_pkg::MAX_BURST)) && (count <= fill_now))
                begin
                    rp_next    = adv(rp_reg, count, slots_reg);
                    res_status = 1'b0;
                    res_fill   = fill_now - count;
                end
            end
            srb_pkg::ACT_CLEAR:
            begin
                wp_next    = '0;
                rp_next    = '0;
                left_next  = '0;
                taken_next = 1'b0;
                res_status = 1'b0;
                res_fill   = '0;
            end
            default:
            begin
                res_status = 1'b1;
            end
        endcase
    end

    assign stat.emit       = emit;
    assign stat.silent     = silent;
    assign stat.emit_count = count[srb_pkg::EMIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= srb_pkg::LEN_W'(srb_pkg::DEPTH);
            wp_reg    <= '0;
            rp_reg    <= '0;
            left_reg  <= '0;
            taken_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            slots_reg <= slots_cfg;
            wp_reg    <= '0;
            rp_reg    <= '0;
            left_reg  <= '0;
            taken_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            left_reg  <= left_next;
            taken_reg <= taken_next;
        end
    end

    // Output payload and stream pointer
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (emit)
            begin
                emit_ptr_reg  <= emit_from;
                emit_fill_reg <= emit_level;
            end
            else
            begin
                sel_reg    <= 1'b0;
                status_reg <= res_status;
                last_reg   <= 1'b1;
                fill_reg   <= res_fill;
            end
        end
        else if (cmd.step)
        begin
            emit_ptr_reg <= adv(emit_ptr_reg, srb_pkg::CNT_W'(1), slots_reg);
            sel_reg      <= 1'b1;
            status_reg   <= 1'b0;
            last_reg     <= cmd.step_last;
            fill_reg     <= emit_fill_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && do_store)
        begin
            mem[wp_reg] <= sample;
        end
        if (cmd.step)
        begin
            rd_data_reg <= mem[emit_ptr_reg];
        end
    end

    assign data_out   = sel_reg ? $signed(rd_data_reg) : '0;
    assign status     = status_reg;
    assign last       = last_reg;
    assign fill_level = fill_reg;

endmodule

// File: design/srb_ctrl.sv
// ----------------------------------------------------------------------------
// srb_ctrl
// Controller: request handshake, sample streaming sequence and output valid.
// ----------------------------------------------------------------------------
module srb_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  srb_pkg::dp_stat_t stat,
    output srb_pkg::dp_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                     state_reg;
    logic [srb_pkg::EMIT_W-1:0] left_reg;
    logic                       out_valid_reg;
    logic                       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;

    always_comb
    begin
        cmd.accept    = in_valid && in_ready;
        cmd.step      = (state_reg == ST_EMIT) && out_free;
        cmd.step_last = (left_reg == srb_pkg::EMIT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.accept)
                    begin
                        if (stat.emit)
                        begin
                            state_reg     <= ST_EMIT;
                            left_reg      <= stat.emit_count;
                            out_valid_reg <= 1'b0;
                        end
                        else
                        begin
                            out_valid_reg <= !stat.silent;
                        end
                    end
                    else if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                ST_EMIT:
                begin
                    if (cmd.step)
                    begin
                        out_valid_reg <= 1'b1;
                        left_reg      <= left_reg - srb_pkg::EMIT_W'(1);
                        if (cmd.step_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: design/sample_ring_buffer_peek_skip_core.sv
// ----------------------------------------------------------------------------
// sample_ring_buffer_peek_skip_core
// Ring of 16-bit samples with burst write, read, preview, skip and clear.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------------
//  request  | in_valid / in_ready  | action, sample, burst_start, count, offset
//  result   | out_valid / out_ready| data_out, status, last, fill_level
//  config   | cfg_valid / cfg_ready| ring_length
//
//  Write, skip, clear and refused requests each give one result once taken; it
//  sits in the output register from the next cycle on; a dropped item gives none.
//  A read or preview of N samples streams N results, one per cycle unless stalled,
//  from the store's single read port; take the next request once the last is loaded.
//  Reset clears pointers and burst state; the store needs no clearing pass.
//  A stall on the result side holds the output and the stream in place.
//
module sample_ring_buffer_peek_skip_core
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srb_pkg::LEN_W-1:0]        ring_length,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [srb_pkg::ACT_W-1:0]        action,
    input  logic signed [srb_pkg::SMP_W-1:0] sample,
    input  logic                             burst_start,
    input  logic [srb_pkg::CNT_W-1:0]        count,
    input  logic [srb_pkg::CNT_W-1:0]        offset,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [srb_pkg::SMP_W-1:0] data_out,
    output logic                             status,
    output logic                             last,
    output logic [srb_pkg::CNT_W-1:0]        fill_level
);

    srb_pkg::dp_cmd_t  cmd;
    srb_pkg::dp_stat_t stat;

    // Config must land only while idle (the block does not enforce this); take it at once
    assign cfg_ready = 1'b1;

    srb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    srb_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .ring_length (ring_length),
        .action      (action),
        .sample      (sample),
        .burst_start (burst_start),
        .count       (count),
        .offset      (offset),
        .cmd         (cmd),
        .stat        (stat),
        .data_out    (data_out),
        .status      (status),
        .last        (last),
        .fill_level  (fill_level)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sample ring buffer core. Drives requests with
// random idle gaps, throttles the result side, predicts every result from a
// cycle-free model of the ring kept in the bench, and compares each result
// field by field in arrival order. Covers directed corner cases, several ring
// lengths including the out-of-range ones, a long output stall and random
// burst/read/preview/skip/clear traffic.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 8;       // covers a dropped burst item still in flight
    localparam int WATCHDOG_LIMIT = 5000;    // cycles without any handshake
    localparam int RANDOM_ITEMS   = 360;
    localparam int PRESSURE_HOLD  = 200;
    localparam int PHASES         = 6;

    // One expected result of the ring
    typedef struct packed {
        logic signed [srb_pkg::SMP_W-1:0] data;
        logic                             status;
        logic                             last;
        logic [srb_pkg::CNT_W-1:0]        level;
    } ring_result_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             cfg_valid   = 1'b0;
    logic                             cfg_ready;
    logic [srb_pkg::LEN_W-1:0]        ring_length = '0;
    logic                             in_valid    = 1'b0;
    logic                             in_ready;
    logic [srb_pkg::ACT_W-1:0]        action      = srb_pkg::ACT_CLEAR;
    logic signed [srb_pkg::SMP_W-1:0] sample      = '0;
    logic                             burst_start = 1'b0;
    logic [srb_pkg::CNT_W-1:0]        count       = '0;
    logic [srb_pkg::CNT_W-1:0]        offset      = '0;
    logic                             out_valid;
    logic                             out_ready   = 1'b0;
    logic signed [srb_pkg::SMP_W-1:0] data_out;
    logic                             status;
    logic                             last;
    logic [srb_pkg::CNT_W-1:0]        fill_level;

    sample_ring_buffer_peek_skip_core u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .ring_length (ring_length),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .sample      (sample),
        .burst_start (burst_start),
        .count       (count),
        .offset      (offset),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .status      (status),
        .last        (last),
        .fill_level  (fill_level)
    );

    // ------------------------------------------------------------------------
    // Predicted ring state: own copy of store, pointers, burst tracking and
    // the ring length register
    // ------------------------------------------------------------------------
    logic signed [srb_pkg::SMP_W-1:0] model_store [srb_pkg::DEPTH];
    int                      model_len         = srb_pkg::DEPTH;
    int                      model_wr          = 0;
    int                      model_rd          = 0;
    int                      model_burst_left  = 0;
    bit                      model_burst_taken = 1'b0;
    ring_result_t            pending_results [$];

    int error_count     = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int refusals_seen   = 0;
    int length_writes   = 0;
    int quiet_cycles    = 0;

    // Idle knobs, changed per test; hold count is consumed by the receiver
    bit tx_idle        = 1'b0;
    bit rx_idle        = 1'b0;
    int rx_hold_cycles = 0;

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int min_of(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // Length 0 acts as 1, anything above DEPTH acts as DEPTH
    function automatic int ring_slots();
        int n;
        n = model_len;
        if (n < 1)
            n = 1;
        if (n > srb_pkg::DEPTH)
            n = srb_pkg::DEPTH;
        return n;
    endfunction

    function automatic int ring_fill();
        if (model_wr >= model_rd)
            return model_wr - model_rd;
        return model_wr + ring_slots() - model_rd;
    endfunction

    function automatic int ring_advance(input int p, input int by);
        return (p + by) % ring_slots();
    endfunction

    function automatic void empty_ring();
        model_wr          = 0;
        model_rd          = 0;
        model_burst_left  = 0;
        model_burst_taken = 1'b0;
    endfunction

    function automatic void expect_result(input logic signed [srb_pkg::SMP_W-1:0] d,
                                          input logic st, input logic lst, input int lv);
        ring_result_t r;
        r.data   = d;
        r.status = st;
        r.last   = lst;
        r.level  = srb_pkg::CNT_W'(lv);
        pending_results.push_back(r);
    endfunction

    // A refused request reports the unchanged fill
    function automatic void expect_refusal();
        expect_result('0, 1'b1, 1'b1, ring_fill());
    endfunction

    function automatic void expect_stream(input int from, input int n, input int lv);
        int p;
        p = from;
        for (int i = 0; i < n; i++)
        begin
            expect_result(model_store[p], 1'b0, i == n - 1, lv);
            p = ring_advance(p, 1);
        end
    endfunction

    function automatic void predict_length_write(input int len);
        model_len = len & 'h7FF;
        empty_ring();
    endfunction

    function automatic void predict_request(input logic [srb_pkg::ACT_W-1:0] act,
                                            input logic signed [srb_pkg::SMP_W-1:0] smp,
                                            input logic st, input int cnt, input int ofs);
        int held;
        int space;
        int from;
        held = ring_fill();
        case (act)
            srb_pkg::ACT_WRITE:
            begin
                if (st)
                begin
                    // Judge the whole burst on its first item
                    space = ring_slots() - 1 - held;
                    if (cnt < 1 || cnt > srb_pkg::MAX_BURST || cnt > space)
                    begin
                        model_burst_taken = 1'b0;
                        model_burst_left  = (cnt > 0) ? cnt - 1 : 0;
                        expect_refusal();
                        return;
                    end
                    model_burst_taken = 1'b1;
                    model_burst_left  = cnt;
                end
                else if (model_burst_left == 0)
                begin
                    // Stray write outside any burst
                    expect_refusal();
                    return;
                end
                else if (!model_burst_taken)
                begin
                    // Tail of a refused burst: drop silently
                    model_burst_left--;
                    return;
                end
                model_store[model_wr] = smp;
                model_wr = ring_advance(model_wr, 1);
                model_burst_left--;
                if (model_burst_left == 0)
                    model_burst_taken = 1'b0;
                expect_result('0, 1'b0, 1'b1, ring_fill());
            end
            srb_pkg::ACT_READ:
            begin
                if (cnt < 1 || cnt > srb_pkg::MAX_BURST || cnt > held)
                begin
                    expect_refusal();
                    return;
                end
                from     = model_rd;
                model_rd = ring_advance(model_rd, cnt);
                expect_stream(from, cnt, held - cnt);
            end
            srb_pkg::ACT_PREVIEW:
            begin
                if (cnt < 1 || cnt > srb_pkg::MAX_BURST || cnt + ofs > held)
                begin
                    expect_refusal();
                    return;
                end
                expect_stream(ring_advance(model_rd, ofs), cnt, held);
            end
            srb_pkg::ACT_SKIP:
            begin
                if (cnt > srb_pkg::MAX_BURST || cnt > held)
                begin
                    expect_refusal();
                    return;
                end
                model_rd = ring_advance(model_rd, cnt);
                expect_result('0, 1'b0, 1'b1, held - cnt);
            end
            srb_pkg::ACT_CLEAR:
            begin
                empty_ring();
                expect_result('0, 1'b0, 1'b1, 0);
            end
            default:
                expect_refusal();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    // Mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    function automatic logic signed [srb_pkg::SMP_W-1:0] rand_sample();
        return srb_pkg::SMP_W'($urandom);
    endfunction

    function automatic int rand_offset();
        return $urandom_range(0, 1022);
    endfunction

    // Keep most bursts and reads short, a fifth of them up to the maximum
    function automatic int burst_cap();
        return ($urandom_range(0, 4) == 0) ? srb_pkg::MAX_BURST : 8;
    endfunction

    // Count for a read or preview: mostly within the fill, sometimes not
    function automatic int usable_count(input int held);
        if (held > 0 && $urandom_range(0, 9) != 0)
            return $urandom_range(1, min_of(held, burst_cap()));
        return $urandom_range(0, srb_pkg::MAX_BURST + 4);
    endfunction

    // ------------------------------------------------------------------------
    // Request sender: hold valid and payload until taken, then predict.
    // Valid stays high on return so back-to-back requests need no extra
    // assignment; the next call or wait_idle decides what it does next.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [srb_pkg::ACT_W-1:0] act,
                                input logic signed [srb_pkg::SMP_W-1:0] smp,
                                input logic st, input int cnt, input int ofs);
        int gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 1) == 0)
            gap = idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        sample      <= smp;
        burst_start <= st;
        count       <= srb_pkg::CNT_W'(cnt);
        offset      <= srb_pkg::CNT_W'(ofs);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(act, smp, st, cnt, ofs);
        items_accepted++;
    endtask

    // Drop valid, drain every expected result, then let in-flight work settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Ring length is only written with the block idle
    task automatic write_ring_length(input int len);
        wait_idle();
        cfg_valid   <= 1'b1;
        ring_length <= srb_pkg::LEN_W'(len);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        predict_length_write(len);
        length_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Write burst of cnt items; a broken burst stops short or runs one over
    // and may carry reads between its items
    task automatic send_burst(input int cnt, input bit broken);
        int follow;
        follow = cnt - 1;
        if (broken)
            follow = $urandom_range(0, cnt);
        send_request(srb_pkg::ACT_WRITE, rand_sample(), 1'b1, cnt, rand_offset());
        repeat (follow)
        begin
            if (broken && $urandom_range(0, 3) == 0)
                send_request(srb_pkg::ACT_READ, rand_sample(), $urandom_range(0, 1), 1,
                             rand_offset());
            send_request(srb_pkg::ACT_WRITE, rand_sample(), 1'b0, $urandom_range(0, 1023),
                         rand_offset());
        end
    endtask

    // One random operation, shaped by the predicted fill so that most of
    // them are legal and reach full, empty and wrapped rings
    task automatic random_request();
        int held;
        int space;
        int cnt;
        int ofs;
        int pick;
        held  = ring_fill();
        space = ring_slots() - 1 - held;
        pick  = $urandom_range(0, 99);
        if (pick < 40)
        begin
            if (space > 0 && $urandom_range(0, 9) != 0)
                cnt = $urandom_range(1, min_of(space, burst_cap()));
            else
                cnt = $urandom_range(1, srb_pkg::MAX_BURST + 8);
            send_burst(cnt, $urandom_range(0, 9) == 0);
        end
        else if (pick < 60)
        begin
            send_request(srb_pkg::ACT_READ, rand_sample(), $urandom_range(0, 1),
                         usable_count(held), rand_offset());
        end
        else if (pick < 75)
        begin
            cnt = usable_count(held);
            if (cnt >= 1 && cnt <= held && $urandom_range(0, 9) != 0)
                ofs = $urandom_range(0, held - cnt);
            else
                ofs = rand_offset();
            send_request(srb_pkg::ACT_PREVIEW, rand_sample(), $urandom_range(0, 1), cnt, ofs);
        end
        else if (pick < 85)
        begin
            if ($urandom_range(0, 9) != 0)
                cnt = $urandom_range(0, min_of(held, srb_pkg::MAX_BURST));
            else
                cnt = $urandom_range(0, 1023);
            send_request(srb_pkg::ACT_SKIP, rand_sample(), $urandom_range(0, 1), cnt,
                         rand_offset());
        end
        else if (pick < 90)
        begin
            send_request(srb_pkg::ACT_CLEAR, rand_sample(), $urandom_range(0, 1),
                         $urandom_range(0, 1023), rand_offset());
        end
        else
        begin
            // Noise: any action, any field value
            send_request(srb_pkg::ACT_W'($urandom_range(0, (1 << srb_pkg::ACT_W) - 1)),
                         rand_sample(), $urandom_range(0, 1), $urandom_range(0, 1023),
                         rand_offset());
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Corner cases on the reset-length ring
    task automatic test_directed_requests();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_request(srb_pkg::ACT_CLEAR, '0, 1'b0, 0, 0);
        send_request(srb_pkg::ACT_READ, '0, 1'b0, 1, 0);          // read on empty ring
        send_request(srb_pkg::ACT_SKIP, '0, 1'b0, 0, 0);          // zero skip is fine
        send_request(srb_pkg::ACT_WRITE, '0, 1'b1, 0, 0);         // zero-length burst
        send_request(srb_pkg::ACT_WRITE, '0, 1'b1, srb_pkg::MAX_BURST + 1, 0); // oversize
        // Full-scale samples; the new burst abandons the refused one
        send_request(srb_pkg::ACT_WRITE, 16'sh8000, 1'b1, 4, 0);
        send_request(srb_pkg::ACT_WRITE, 16'sh7FFF, 1'b0, 0, 0);
        send_request(srb_pkg::ACT_WRITE, 16'sh0000, 1'b0, 0, 0);
        send_request(srb_pkg::ACT_WRITE, -16'sd1, 1'b0, 0, 0);
        send_request(srb_pkg::ACT_WRITE, 16'sh1234, 1'b0, 0, 0);  // stray write
        send_request(srb_pkg::ACT_PREVIEW, '0, 1'b0, 2, 2);
        send_request(srb_pkg::ACT_PREVIEW, '0, 1'b0, 2, 3);       // beyond the fill
        send_request(srb_pkg::ACT_PREVIEW, '0, 1'b0, 0, 0);
        send_request(srb_pkg::ACT_READ, '0, 1'b0, 5, 0);          // more than held
        send_request(srb_pkg::ACT_SKIP, '0, 1'b0, srb_pkg::MAX_BURST + 1, 0);
        send_request(srb_pkg::ACT_READ, '0, 1'b0, 1, 0);
        send_request(srb_pkg::ACT_SKIP, '0, 1'b0, 1, 0);
        for (int a = srb_pkg::ACT_CLEAR + 1; a < (1 << srb_pkg::ACT_W); a++)
            send_request(srb_pkg::ACT_W'(a), '0, 1'b0, 1, 0);      // undefined actions
        // Read in the middle of a burst leaves the burst running
        send_request(srb_pkg::ACT_WRITE, 16'sh0101, 1'b1, 3, 0);
        send_request(srb_pkg::ACT_READ, '0, 1'b0, 1, 0);
        send_request(srb_pkg::ACT_WRITE, 16'sh0202, 1'b0, 0, 0);
        send_request(srb_pkg::ACT_WRITE, 16'sh0303, 1'b0, 0, 0);
        // New burst start in the middle of a burst
        send_request(srb_pkg::ACT_WRITE, 16'sh0404, 1'b1, 3, 0);
        send_request(srb_pkg::ACT_WRITE, 16'sh0505, 1'b1, 1, 0);
        // Clear ends a burst, so the next item is stray
        send_request(srb_pkg::ACT_WRITE, 16'sh0606, 1'b1, 3, 0);
        send_request(srb_pkg::ACT_CLEAR, '0, 1'b0, 0, 0);
        send_request(srb_pkg::ACT_WRITE, 16'sh0707, 1'b0, 0, 0);
        // Refused long burst: its tail items vanish without a result
        send_request(srb_pkg::ACT_WRITE, 16'sh0808, 1'b1, 1023, 1022);
        send_request(srb_pkg::ACT_WRITE, 16'sh0909, 1'b0, 0, 0);
        send_request(srb_pkg::ACT_CLEAR, '0, 1'b0, 0, 0);
        send_request(srb_pkg::ACT_PREVIEW, '0, 1'b0, 1, 1022);
        wait_idle();
    endtask

    // Degenerate, tiny, wrapping and oversized ring lengths
    task automatic test_ring_lengths();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        write_ring_length(0);
        send_request(srb_pkg::ACT_WRITE, rand_sample(), 1'b1, 1, 0);
        send_request(srb_pkg::ACT_READ, '0, 1'b0, 1, 0);
        send_request(srb_pkg::ACT_SKIP, '0, 1'b0, 0, 0);
        write_ring_length(1);
        send_request(srb_pkg::ACT_WRITE, rand_sample(), 1'b1, 1, 0);
        write_ring_length(2);
        send_burst(1, 1'b0);
        send_request(srb_pkg::ACT_WRITE, rand_sample(), 1'b1, 1, 0);  // ring full
        send_request(srb_pkg::ACT_READ, '0, 1'b0, 1, 0);
        write_ring_length(5);
        send_burst(4, 1'b0);
        send_request(srb_pkg::ACT_WRITE, rand_sample(), 1'b1, 1, 0);  // ring full
        send_request(srb_pkg::ACT_READ, '0, 1'b0, 3, 0);
        send_burst(3, 1'b0);                                          // wraps the write pointer
        send_request(srb_pkg::ACT_PREVIEW, '0, 1'b0, 4, 0);
        send_request(srb_pkg::ACT_READ, '0, 1'b0, 4, 0);
        write_ring_length(2047);
        send_burst(2, 1'b0);
        send_request(srb_pkg::ACT_READ, '0, 1'b0, 2, 0);
        wait_idle();
    endtask

    // Hold the result side off while requests keep coming, so the block
    // backs up and stalls its input
    task automatic test_backpressure();
        write_ring_length(100);
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        rx_hold_cycles = PRESSURE_HOLD;
        send_burst(40, 1'b0);
        send_request(srb_pkg::ACT_PREVIEW, '0, 1'b0, 30, 5);
        send_request(srb_pkg::ACT_READ, '0, 1'b0, 40, 0);
        wait_idle();
    endtask

    // Random traffic across ring lengths and idle settings
    task automatic test_random_traffic();
        int lengths [PHASES];
        int stop_at;
        lengths = '{srb_pkg::DEPTH, 6, 70, 2, 2047, 0};
        lengths[PHASES-1] = $urandom_range(3, srb_pkg::DEPTH);
        for (int i = 0; i < PHASES; i++)
        begin
            write_ring_length(lengths[i]);
            // First phase runs flat out on both sides
            if (i == 0)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            else
            begin
                tx_idle = (i % 3) != 1;
                rx_idle = (i % 3) != 2;
            end
            stop_at = items_accepted + RANDOM_ITEMS / PHASES;
            while (items_accepted < stop_at)
                random_request();
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: ready with random stalls, plus the long hold-off that
    // the backpressure test asks for, counted here
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                out_ready <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (idle_length()) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each taken result with the oldest expectation
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string what, input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status === 1'b1)
                refusals_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, got data %0d status %0b fill %0d",
                         $time, data_out, status, fill_level);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("data_out", want.data, data_out);
                compare_field("status", {31'd0, want.status}, {31'd0, status});
                compare_field("last", {31'd0, want.last}, {31'd0, last});
                compare_field("fill_level", {22'd0, want.level}, {22'd0, fill_level});
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no channel moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results still expected",
                     $time, WATCHDOG_LIMIT, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < srb_pkg::DEPTH; i++)
            model_store[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_requests();
        test_ring_lengths();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        $display("Run: %0d requests taken, %0d results checked (%0d refused), %0d length writes",
                 items_accepted, results_checked, refusals_seen, length_writes);
        $display("Covered corner requests, ring lengths 0 to 2047, a %0d-cycle output hold, %s",
                 PRESSURE_HOLD, "random bursts, reads, previews and skips with idle gaps");
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
design/srb_pkg.sv
design/srb_dp.sv
design/srb_ctrl.sv
design/sample_ring_buffer_peek_skip_core.sv
tb/tb_top.sv
